FILE: src/blup_pkg.sv
// Shared types, constants and helpers for the bilinear upscaler.
// Used by blup_front, blup_queue, blup_back, blup_chk and the top level.
// No dependencies.
package blup_pkg;

    // Geometry
    localparam int DEST_HEIGHT = 40;
    localparam int DEST_WIDTH  = 40;
    localparam int SOURCE_MAX  = 64;
    localparam int DH = DEST_HEIGHT - 1;
    localparam int DW = DEST_WIDTH - 1;

    // Field widths
    localparam int IDX_W     = 6;
    localparam int SIZE_W    = 7;
    localparam int SAMPLE_W  = 16;
    localparam int CFG_IDX_W = 2;

    // Frame store addressing (row and column concatenated)
    localparam int AW          = $clog2(SOURCE_MAX);
    localparam int STORE_AW    = 2 * AW;
    localparam int STORE_DEPTH = SOURCE_MAX * SOURCE_MAX;

    // Source position: n = m * (size - 1), split by reciprocal multiply
    localparam int FRAC_W     = IDX_W;
    localparam int POS_W      = 2 * IDX_W;
    localparam int POS_SHIFT  = 16;
    localparam int RECIP_W    = 17;
    localparam int RECIP_ROW  = ((1 << POS_SHIFT) + DH - 1) / DH;
    localparam int RECIP_COL  = ((1 << POS_SHIFT) + DW - 1) / DW;
    localparam int POS_PROD_W = POS_W + RECIP_W;

    // Blend arithmetic
    localparam int WT_W   = 2 * FRAC_W;
    localparam int PROD_W = SAMPLE_W + WT_W + 1;
    localparam int ACC_W  = PROD_W + 2;

    // Final divide by DH*DW, round half up, via a biased reciprocal multiply
    localparam int DEN        = DH * DW;
    localparam int ROUND      = DEN / 2;
    localparam int BIAS       = (1 << (SAMPLE_W - 1)) * DEN;
    localparam int M_W        = 28;
    localparam int DIV_SHIFT  = 38;
    localparam int RD_W       = 29;
    localparam logic [63:0] RECIP_DEN = ((64'd1 << DIV_SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN);
    localparam int QP_W       = M_W + RD_W;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd1;

    // Work item handed from front to back
    typedef struct packed {
        logic                is_query;
        logic                load_ok;
        logic [IDX_W-1:0]    row0;
        logic [IDX_W-1:0]    row1;
        logic [IDX_W-1:0]    col0;
        logic [IDX_W-1:0]    col1;
        logic [FRAC_W-1:0]   frac_r;
        logic [FRAC_W-1:0]   frac_c;
        logic [SAMPLE_W-1:0] value;
        logic [IDX_W-1:0]    mh;
        logic [IDX_W-1:0]    mw;
    } t_task;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_DIV,
        F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_WAIT,
        B_ADD,
        B_MUL,
        B_OUT
    } t_bstate;

    // Size register to (clamped size - 1): zero reads as one, large as SOURCE_MAX
    function automatic logic [AW-1:0] size_m1(input logic [SIZE_W-1:0] v);
        if (v == '0) begin
            return '0;
        end else if (v > SIZE_W'(SOURCE_MAX)) begin
            return AW'(SOURCE_MAX - 1);
        end else begin
            return AW'(v - SIZE_W'(1));
        end
    endfunction

endpackage

FILE: src/bilinear_upscale_align_corners.sv
// Bilinear upscaler, aligned corners, to a fixed 40x40 grid.
// A query passes front end states multiply, divide and push; a load goes straight to push.
// The back end finishes one query before it takes the next: four serial reads on the single
// frame store read port, then a rounding add, a reciprocal multiply and the output.
// Synchronous active-low reset clears control, queue and result valid; the frame
// store is not cleared and sizes return to 20x20. Depends on blup_pkg and submodules.
module bilinear_upscale_align_corners import blup_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 i_cmd,
    input  logic [IDX_W-1:0]     i_load_row,
    input  logic [IDX_W-1:0]     i_load_col,
    input  logic [SAMPLE_W-1:0]  i_sample_value,
    input  logic [IDX_W-1:0]     i_dest_row,
    input  logic [IDX_W-1:0]     i_dest_col,
    input  logic                 i_last_in_frame,
    output logic                 empty,
    input  logic                 pop,
    output logic [SAMPLE_W-1:0]  o_pixel_value,
    output logic [IDX_W-1:0]     o_pixel_row,
    output logic [IDX_W-1:0]     o_pixel_col,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SIZE_W-1:0]    i_cfg_data
);

    t_task w_ftask, w_btask;
    logic  w_fpush, w_qfull, w_qempty, w_bpop;

    // front: accept and classify (frame end marker carries no behavior)
    blup_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_cmd          (i_cmd),
        .i_load_row     (i_load_row),
        .i_load_col     (i_load_col),
        .i_sample_value (i_sample_value),
        .i_dest_row     (i_dest_row),
        .i_dest_col     (i_dest_col),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_task         (w_ftask),
        .o_task_push    (w_fpush),
        .i_task_full    (w_qfull)
    );

    blup_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fpush),
        .i_data  (w_ftask),
        .o_full  (w_qfull),
        .i_pop   (w_bpop),
        .o_data  (w_btask),
        .o_empty (w_qempty)
    );

    blup_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_task        (w_btask),
        .i_task_empty  (w_qempty),
        .o_task_pop    (w_bpop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_pixel_value (o_pixel_value),
        .o_pixel_row   (o_pixel_row),
        .o_pixel_col   (o_pixel_col)
    );

endmodule

FILE: src/blup_front.sv
// Front end: takes items, holds size registers, computes neighbour indices
// and fractions for queries. Depends on blup_pkg.
module blup_front import blup_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic                 i_cmd,
    input  logic [IDX_W-1:0]     i_load_row,
    input  logic [IDX_W-1:0]     i_load_col,
    input  logic [SAMPLE_W-1:0]  i_sample_value,
    input  logic [IDX_W-1:0]     i_dest_row,
    input  logic [IDX_W-1:0]     i_dest_col,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SIZE_W-1:0]    i_cfg_data,
    output t_task                o_task,
    output logic                 o_task_push,
    input  logic                 i_task_full
);

    t_fstate r_state, n_state;

    logic [SIZE_W-1:0]   r_height, r_width;
    logic                r_cmd;
    logic [IDX_W-1:0]    r_row, r_col;
    logic [SAMPLE_W-1:0] r_value;
    logic [IDX_W-1:0]    r_mh, r_mw;
    logic [AW-1:0]       r_hm1, r_wm1;
    logic [POS_W-1:0]    r_nh, r_nw;
    logic [IDX_W-1:0]    r_h0, r_w0;

    logic                w_accept;
    logic [POS_PROD_W-1:0] w_qh, w_qw;
    logic [POS_W-1:0]    w_rem_h, w_rem_w;
    logic                w_load_ok;

    assign w_accept    = i_push && !o_full;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= SIZE_W'(20);
            r_width  <= SIZE_W'(20);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SOURCE_HEIGHT: r_height <= i_cfg_data;
                CFG_SOURCE_WIDTH:  r_width  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    n_state = (i_cmd == CMD_QUERY) ? F_MUL : F_PUSH;
                end
            end
            F_MUL:  n_state = F_DIV;
            F_DIV:  n_state = F_PUSH;
            F_PUSH: begin
                if (!i_task_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    // Item capture and position arithmetic
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_cmd;
            r_row   <= i_load_row;
            r_col   <= i_load_col;
            r_value <= i_sample_value;
            r_mh    <= (i_dest_row > IDX_W'(DH)) ? IDX_W'(DH) : i_dest_row;
            r_mw    <= (i_dest_col > IDX_W'(DW)) ? IDX_W'(DW) : i_dest_col;
            r_hm1   <= size_m1(r_height);
            r_wm1   <= size_m1(r_width);
        end
        if (r_state == F_MUL) begin
            r_nh <= POS_W'(r_mh) * POS_W'(r_hm1);
            r_nw <= POS_W'(r_mw) * POS_W'(r_wm1);
        end
        if (r_state == F_DIV) begin
            r_h0 <= w_qh[POS_SHIFT +: IDX_W];
            r_w0 <= w_qw[POS_SHIFT +: IDX_W];
        end
    end

    // Whole part by reciprocal multiply (exact over the position range)
    assign w_qh = POS_PROD_W'(r_nh) * POS_PROD_W'(RECIP_ROW);
    assign w_qw = POS_PROD_W'(r_nw) * POS_PROD_W'(RECIP_COL);

    // Remainders
    assign w_rem_h = r_nh - POS_W'(r_h0) * POS_W'(DH);
    assign w_rem_w = r_nw - POS_W'(r_w0) * POS_W'(DW);

    assign w_load_ok = ({1'b0, r_row} < (IDX_W + 1)'(SOURCE_MAX))
                    && ({1'b0, r_col} < (IDX_W + 1)'(SOURCE_MAX));

    // Outputs
    always_comb begin
        o_full      = (r_state != F_IDLE);
        o_task_push = (r_state == F_PUSH) && !i_task_full;
        o_task      = '0;
        o_task.is_query = (r_cmd == CMD_QUERY);
        o_task.value    = r_value;
        o_task.mh       = r_mh;
        o_task.mw       = r_mw;
        if (r_cmd == CMD_QUERY) begin
            o_task.row0   = r_h0;
            o_task.col0   = r_w0;
            o_task.row1   = (r_h0 < r_hm1) ? r_h0 + IDX_W'(1) : r_hm1;
            o_task.col1   = (r_w0 < r_wm1) ? r_w0 + IDX_W'(1) : r_wm1;
            o_task.frac_r = w_rem_h[FRAC_W-1:0];
            o_task.frac_c = w_rem_w[FRAC_W-1:0];
        end else begin
            o_task.row0    = r_row;
            o_task.col0    = r_col;
            o_task.load_ok = w_load_ok;
        end
    end

endmodule

FILE: src/blup_queue.sv
// Short queue of work items between front and back ends.
// Depends on blup_pkg.
module blup_queue import blup_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_task i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_task o_data,
    output logic  o_empty
);

    t_task              r_slot [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr, r_rptr;
    logic [QPTR_W:0]    r_count;

    logic w_push, w_pop;

    assign o_full  = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_slot[r_rptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + (QPTR_W + 1)'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - (QPTR_W + 1)'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

endmodule

FILE: src/blup_back.sv
// Back end: frame store, four serial neighbour reads, weighted sum,
// rounded divide and the result register. Depends on blup_pkg.
module blup_back import blup_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_task               i_task,
    input  logic                i_task_empty,
    output logic                o_task_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [SAMPLE_W-1:0] o_pixel_value,
    output logic [IDX_W-1:0]    o_pixel_row,
    output logic [IDX_W-1:0]    o_pixel_col
);

    t_bstate r_state, n_state;

    logic [SAMPLE_W-1:0]      r_mem [STORE_DEPTH];
    t_task                    r_task;
    logic [1:0]               r_k;
    logic [SAMPLE_W-1:0]      r_rdata;
    logic [WT_W-1:0]          r_wt;
    logic                     r_v1, r_v2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [M_W-1:0]           r_m;
    logic [QP_W-1:0]          r_qp;
    logic                     r_ovalid;
    logic [SAMPLE_W-1:0]      r_pix;
    logic [IDX_W-1:0]         r_prow, r_pcol;

    logic                w_we;
    logic [STORE_AW-1:0] w_waddr, w_raddr;
    logic [IDX_W-1:0]    w_rrow, w_rcol;
    logic [FRAC_W-1:0]   w_wa, w_wb;
    logic [WT_W-1:0]     w_wt;
    logic                w_out_load;
    logic [SAMPLE_W-1:0] w_q;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_task_empty && i_task.is_query) begin
                    n_state = B_READ;
                end
            end
            B_READ: begin
                if (r_k == 2'd3) begin
                    n_state = B_WAIT;
                end
            end
            B_WAIT: begin
                if (!r_v1) begin
                    n_state = B_ADD;
                end
            end
            B_ADD:  n_state = B_MUL;
            B_MUL:  n_state = B_OUT;
            B_OUT: begin
                if (w_out_load) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_task_pop = (r_state == B_IDLE) && !i_task_empty;
        w_we       = o_task_pop && !i_task.is_query && i_task.load_ok;
        w_out_load = (r_state == B_OUT) && (!r_ovalid || i_pop);
    end

    // Neighbour select and weight for read step k
    always_comb begin
        case (r_k)
            2'd0: begin
                w_rrow = r_task.row0; w_rcol = r_task.col0;
                w_wa   = FRAC_W'(DH) - r_task.frac_r;
                w_wb   = FRAC_W'(DW) - r_task.frac_c;
            end
            2'd1: begin
                w_rrow = r_task.row0; w_rcol = r_task.col1;
                w_wa   = FRAC_W'(DH) - r_task.frac_r;
                w_wb   = r_task.frac_c;
            end
            2'd2: begin
                w_rrow = r_task.row1; w_rcol = r_task.col0;
                w_wa   = r_task.frac_r;
                w_wb   = FRAC_W'(DW) - r_task.frac_c;
            end
            default: begin
                w_rrow = r_task.row1; w_rcol = r_task.col1;
                w_wa   = r_task.frac_r;
                w_wb   = r_task.frac_c;
            end
        endcase
    end

    assign w_wt    = WT_W'(w_wa) * WT_W'(w_wb);
    assign w_raddr = {w_rrow[AW-1:0], w_rcol[AW-1:0]};
    assign w_waddr = {i_task.row0[AW-1:0], i_task.col0[AW-1:0]};

    // Frame store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= i_task.value;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // Pipeline valids and read counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_k  <= '0;
        end else begin
            r_v1 <= (r_state == B_READ);
            r_v2 <= r_v1;
            if (r_state == B_READ) begin
                r_k <= r_k + 2'd1;
            end else begin
                r_k <= '0;
            end
        end
    end

    // Weighted sum and divide datapath
    always_ff @(posedge i_clk) begin
        if (o_task_pop && i_task.is_query) begin
            r_task <= i_task;
        end
        r_wt   <= w_wt;
        r_prod <= $signed(r_rdata) * $signed({1'b0, r_wt});
        if (o_task_pop) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        // bias keeps the numerator positive so the quotient is a floor
        if (r_state == B_ADD) begin
            r_m <= M_W'(r_acc + ACC_W'(ROUND + BIAS));
        end
        if (r_state == B_MUL) begin
            r_qp <= QP_W'(r_m) * QP_W'(RECIP_DEN);
        end
    end

    // Quotient minus the bias of one half range is a flip of the top bit
    assign w_q = r_qp[DIV_SHIFT +: SAMPLE_W];

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_pop) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_pix  <= {~w_q[SAMPLE_W-1], w_q[SAMPLE_W-2:0]};
            r_prow <= r_task.mh;
            r_pcol <= r_task.mw;
        end
    end

    assign o_empty       = !r_ovalid;
    assign o_pixel_value = r_pix;
    assign o_pixel_row   = r_prow;
    assign o_pixel_col   = r_pcol;

endmodule

FILE: src/blup_chk.sv
// Port-level checks for the bilinear upscaler, bound to the top level.
// Depends on blup_pkg and bilinear_upscale_align_corners.
module blup_chk import blup_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 push,
    input logic                 full,
    input logic                 empty,
    input logic                 pop,
    input logic [SAMPLE_W-1:0]  o_pixel_value,
    input logic [IDX_W-1:0]     o_pixel_row,
    input logic [IDX_W-1:0]     o_pixel_col
);

    // A waiting result is held until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_pixel_value)
                              && $stable(o_pixel_row) && $stable(o_pixel_col)))
        else $error("result changed while stalled");

    // Reported destination is always saturated into the grid
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_pixel_row <= IDX_W'(DH) && o_pixel_col <= IDX_W'(DW)))
        else $error("result destination outside grid");

    // Reset leaves no result and an open input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("reset did not clear handshake state");

endmodule

bind bilinear_upscale_align_corners blup_chk u_chk (.*);
